@@ rtl/core/dcg_pkg.sv @@
// dcg_pkg: shared types and constants of the coincidence grouper
// no dependencies
package dcg_pkg;
	localparam int MaxSignalsDef = 64;
	localparam int MetaW = 224;
	localparam int TimeW = 48;
	localparam int AmpW = 32;
	localparam int DetW = 4;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 32;
	localparam int GroupW = 6;
	localparam int SlotW = 6;

	localparam logic [CfgIdxW-1:0] CFG_THRESH = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_WINDOW = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_OFFSET = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT  = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_BUILD = 1'b1;

	typedef struct packed {
		logic [31:0] run_id;
		logic [31:0] event_time;
		logic [63:0] ps_time;
		logic [31:0] bunch_number;
		logic [31:0] ps_pulse;
		logic [31:0] pulse_intensity;
		logic [3:0] detector;
		logic signed [47:0] flight_time;
		logic signed [31:0] amplitude;
		logic opcode;
	} in_item_t;

	typedef struct packed {
		logic [5:0] group_number;
		logic [5:0] member_slot;
		logic [3:0] member_detector;
		logic signed [47:0] member_time;
		logic signed [31:0] member_amplitude;
		logic last_of_group;
		logic all_done;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // write input item into store at hit count
		logic rd_anchor;   // read store at anchor cursor
		logic cap_anchor;  // capture anchor read data
		logic rd_scan;     // read store at scan index
		logic scan_init;   // scan index = cursor + 1
		logic scan_step;   // advance scan index
		logic cursor_inc;  // advance anchor cursor
		logic mark;        // mark scan entry and anchor used
		logic hold_emit;   // emit current candidate into pending
		logic emit_anchor; // next emit is anchor
		logic emit_done;   // emit done item
		logic flush;       // flush pending as last of group
		logic grp_inc;     // bump group counter
	} dcg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cursor_end;  // no anchor left
		logic scan_end;    // scan index past last hit
		logic anchor_ok;   // anchor unused and above threshold
		logic match;       // scan entry joins group
		logic pend_valid;  // a member waits for its successor
		logic out_busy;    // output register full and not taken
	} dcg_stat_t;
endpackage

@@ rtl/core/dcg_if.sv @@
// dcg_if: valid/ready channel carrying one item
// depends on nothing; payload type is a parameter
interface dcg_if #(parameter type item_t = logic) (input logic clk);
	logic valid;
	logic ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/dcg_ram.sv @@
// dcg_ram: generic single-port ram with registered read
// no dependencies
module dcg_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	// read before write: a read at the written address returns the old data; read registered
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/core/dcg_datapath.sv @@
// dcg_datapath: hit store, cursors, compare logic and output register
// depends on dcg_pkg and dcg_ram
module dcg_datapath #(
	parameter int MaxSignals = dcg_pkg::MaxSignalsDef
) (
	input logic clk,
	input logic arst_n,
	input dcg_pkg::dcg_cmd_t cmd,
	output dcg_pkg::dcg_stat_t stat,
	input dcg_pkg::in_item_t in_item,
	input logic cfg_we,
	input logic [dcg_pkg::CfgIdxW-1:0] cfg_index,
	input logic [dcg_pkg::CfgDataW-1:0] cfg_data,
	output dcg_pkg::out_item_t out_item,
	output logic out_valid,
	input logic out_ready
);
	import dcg_pkg::*;
	localparam int AW = (MaxSignals > 1) ? $clog2(MaxSignals) : 1;
	localparam int CW = $clog2(MaxSignals + 1);
	localparam int RW = MetaW + DetW + TimeW + AmpW;

	logic signed [31:0] thresh_q, offset_q;
	logic [31:0] window_q;
	logic [3:0] limit_q;
	logic [CW-1:0] count_q, cursor_q, scan_q;
	logic [GroupW-1:0] group_q;
	logic [MaxSignals-1:0] used_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 32'sd400;
			window_q <= 32'd100000;
			offset_q <= 32'sd15000;
			limit_q <= 4'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESH: thresh_q <= cfg_data;
				CFG_WINDOW: window_q <= cfg_data;
				CFG_OFFSET: offset_q <= cfg_data;
				CFG_LIMIT: limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// offset adjust for detectors below the limit, with saturation
	logic signed [TimeW:0] adj_sum;
	logic signed [TimeW-1:0] adj_time;
	always_comb begin
		adj_sum = {in_item.flight_time[TimeW-1], in_item.flight_time};
		if (in_item.detector < limit_q)
			adj_sum = adj_sum + (TimeW+1)'(offset_q);
		if (adj_sum[TimeW] != adj_sum[TimeW-1])
			adj_time = adj_sum[TimeW] ? {1'b1, {(TimeW-1){1'b0}}} : {1'b0, {(TimeW-1){1'b1}}};
		else
			adj_time = adj_sum[TimeW-1:0];
	end

	// anchor and scan bookkeeping
	logic [MetaW-1:0] a_meta_q;
	logic [DetW-1:0] a_det_q;
	logic signed [TimeW-1:0] a_time_q;
	logic signed [AmpW-1:0] a_amp_q;
	logic [AW-1:0] a_slot_q, r_slot_q;
	logic [CW-1:0] rd_idx;
	assign rd_idx = cmd.rd_anchor ? cursor_q : scan_q;

	// store memory; between reads the last read entry is read again so data holds
	logic [RW-1:0] wdata, rdata;
	logic [AW-1:0] addr;
	logic store_full;
	assign store_full = (count_q == CW'(MaxSignals));
	assign wdata = {in_item.run_id, in_item.event_time, in_item.ps_time, in_item.bunch_number,
		in_item.ps_pulse, in_item.pulse_intensity, in_item.detector, adj_time,
		in_item.amplitude};
	always_comb begin
		if (cmd.load) addr = count_q[AW-1:0];
		else if (cmd.rd_anchor) addr = cursor_q[AW-1:0];
		else if (cmd.rd_scan) addr = scan_q[AW-1:0];
		else addr = r_slot_q;
	end
	dcg_ram #(.Width(RW), .Depth(MaxSignals)) u_store (
		.clk(clk), .we(cmd.load && !store_full), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [MetaW-1:0] r_meta;
	logic [DetW-1:0] r_det;
	logic signed [TimeW-1:0] r_time;
	logic signed [AmpW-1:0] r_amp;
	assign {r_meta, r_det, r_time, r_amp} = rdata;

	always_ff @(posedge clk) begin
		if (cmd.rd_anchor || cmd.rd_scan) r_slot_q <= rd_idx[AW-1:0];
		if (cmd.cap_anchor) begin
			a_meta_q <= r_meta; a_det_q <= r_det; a_time_q <= r_time; a_amp_q <= r_amp;
			a_slot_q <= r_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; cursor_q <= '0; scan_q <= '0; group_q <= '0; used_q <= '0;
		end else begin
			if (cmd.load && !store_full) begin
				count_q <= count_q + 1'b1;
				used_q[count_q[AW-1:0]] <= 1'b0;
			end
			if (cmd.cursor_inc) cursor_q <= cursor_q + 1'b1;
			// scan starts at the hit after the anchor
			if (cmd.scan_init) scan_q <= cursor_q + 1'b1;
			else if (cmd.scan_step) scan_q <= scan_q + 1'b1;
			if (cmd.mark) begin
				used_q[r_slot_q] <= 1'b1;
				used_q[a_slot_q] <= 1'b1;
			end
			if (cmd.grp_inc) group_q <= group_q + 1'b1;
		end
	end

	// compare on registered read data
	logic signed [TimeW:0] dt;
	logic [TimeW:0] adt;
	assign dt = {r_time[TimeW-1], r_time} - {a_time_q[TimeW-1], a_time_q};
	assign adt = dt[TimeW] ? -dt : dt;
	assign stat.anchor_ok = !used_q[r_slot_q] && (r_amp > thresh_q);
	assign stat.match = !used_q[r_slot_q] && (r_amp > thresh_q) && (r_meta == a_meta_q)
		&& (adt < {17'd0, window_q});
	assign stat.cursor_end = (cursor_q >= count_q);
	assign stat.scan_end = (scan_q >= count_q);

	// pending member and output register
	out_item_t pend_q, done_item, last_item;
	logic pend_v_q;
	assign stat.pend_valid = pend_v_q;
	assign stat.out_busy = out_valid && !out_ready;

	// done item and last member of a group
	always_comb begin
		done_item = '0;
		done_item.all_done = 1'b1;
		last_item = pend_q;
		last_item.last_of_group = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (cmd.emit_done) begin
				out_valid <= 1'b1;
				out_item <= done_item;
			end else if (cmd.hold_emit && pend_v_q) begin
				out_valid <= 1'b1;
				out_item <= pend_q;
			end else if (cmd.flush) begin
				out_valid <= 1'b1;
				out_item <= last_item;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cmd.hold_emit) begin
				pend_v_q <= 1'b1;
				pend_q.group_number <= group_q;
				pend_q.last_of_group <= 1'b0;
				pend_q.all_done <= 1'b0;
				if (cmd.emit_anchor) begin
					pend_q.member_slot <= SlotW'(a_slot_q);
					pend_q.member_detector <= a_det_q;
					pend_q.member_time <= a_time_q;
					pend_q.member_amplitude <= a_amp_q;
				end else begin
					pend_q.member_slot <= SlotW'(r_slot_q);
					pend_q.member_detector <= r_det;
					pend_q.member_time <= r_time;
					pend_q.member_amplitude <= r_amp;
				end
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end
endmodule

@@ rtl/core/dcg_ctrl.sv @@
// dcg_ctrl: sequencer for load and build steps
// depends on dcg_pkg
module dcg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_opcode,
	output logic in_ready,
	input dcg_pkg::dcg_stat_t stat,
	output dcg_pkg::dcg_cmd_t cmd
);
	import dcg_pkg::*;
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_AREAD = 8'b00000010,
		S_ACHK = 8'b00000100,
		S_SREAD = 8'b00001000,
		S_SCHK = 8'b00010000,
		S_ANCH = 8'b00100000,
		S_FLUSH = 8'b01000000,
		S_DONE = 8'b10000000
	} state_t;
	state_t state_q, state_d;
	logic found_q, found_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		found_d = found_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (in_valid) begin
				if (in_opcode == OP_LOAD) cmd.load = 1'b1;
				else state_d = S_AREAD;
			end
			S_AREAD: begin
				if (stat.cursor_end) state_d = S_DONE;
				else begin
					cmd.rd_anchor = 1'b1;
					cmd.cursor_inc = 1'b1;
					cmd.scan_init = 1'b1;
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				cmd.cap_anchor = 1'b1;
				found_d = 1'b0;
				state_d = stat.anchor_ok ? S_SREAD : S_AREAD;
			end
			S_SREAD: begin
				if (stat.scan_end) state_d = found_q ? S_FLUSH : S_AREAD;
				else begin
					cmd.rd_scan = 1'b1;
					cmd.scan_step = 1'b1;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (stat.match) begin
					if (!stat.out_busy) begin
						if (!found_q) begin
							cmd.hold_emit = 1'b1;
							cmd.emit_anchor = 1'b1;
							found_d = 1'b1;
							state_d = S_ANCH;
						end else begin
							cmd.hold_emit = 1'b1;
							cmd.mark = 1'b1;
							state_d = S_SREAD;
						end
					end
				end else state_d = S_SREAD;
			end
			S_ANCH: if (!stat.out_busy) begin
				cmd.hold_emit = 1'b1;
				cmd.mark = 1'b1;
				state_d = S_SREAD;
			end
			S_FLUSH: if (!stat.out_busy) begin
				cmd.flush = 1'b1;
				cmd.grp_inc = 1'b1;
				state_d = S_IDLE;
			end
			S_DONE: if (!stat.out_busy) begin
				cmd.emit_done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; found_q <= 1'b0;
		end else begin
			state_q <= state_d; found_q <= found_d;
		end
	end
endmodule

@@ rtl/core/detector_coincidence_grouper.sv @@
// detector_coincidence_grouper: top level joining sequencer and datapath
// depends on dcg_pkg, dcg_if, dcg_ctrl, dcg_datapath
module detector_coincidence_grouper #(
	parameter int MaxSignals = dcg_pkg::MaxSignalsDef
) (
	input logic clk,
	input logic arst_n,
	dcg_if.sink in_ch,
	dcg_if.source out_ch,
	input logic cfg_we,
	input logic [dcg_pkg::CfgIdxW-1:0] cfg_index,
	input logic [dcg_pkg::CfgDataW-1:0] cfg_data
);
	// Load items can follow back to back. A build item walks the hit store
	// through its single read port: each anchor tried is read and then
	// checked, and for an anchor that passes, each later stored hit is read
	// and checked in turn. Finding the anchor's first partner adds a step,
	// and the done item follows when no anchor is left. A build ends when it
	// closes its first group or issues the done item; the input is not ready
	// again until then. Results leave through a one-deep output register behind
	// one pending member; while the output is stalled a step that would emit waits.
	import dcg_pkg::*;
	dcg_cmd_t cmd;
	dcg_stat_t stat;

	dcg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_opcode(in_ch.data.opcode),
		.in_ready(in_ch.ready), .stat(stat), .cmd(cmd)
	);
	dcg_datapath #(.MaxSignals(MaxSignals)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_item(in_ch.data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_item(out_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready)
	);

	// a member is never emitted while the output register holds one not yet taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hold_emit && stat.pend_valid) |-> !stat.out_busy)
		else $error("output overrun");
	// loads only in idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ch.ready)
		else $error("load outside idle");
	// a flush always has a pending member
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> stat.pend_valid)
		else $error("flush with nothing pending");
endmodule
